@@ rtl/cau_pkg.sv @@
`default_nettype none

package cau_pkg;

    localparam int FRAC_BITS_DEF = 16;
    // quotient bits produced by the divider; anything at or above 2^QUO_BITS saturates
    localparam int QUO_BITS = 34;
    localparam int DEN_W    = 64;
    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_NEG = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4
    } t_op;

    // sideband that rides along the divider chain
    typedef struct packed {
        logic        is_div;
        logic        dz;
        logic        big_re;
        logic        big_im;
        logic        neg_re;
        logic        neg_im;
        logic [31:0] lin_re;
        logic [31:0] lin_im;
        logic        lin_ovf;
    } t_side;

    // one restoring-division lane
    typedef struct packed {
        logic [DEN_W-1:0]    rem;
        logic [QUO_BITS-1:0] num;
        logic [QUO_BITS-1:0] quo;
    } t_lane;

endpackage

`default_nettype wire

@@ rtl/cau_prep.sv @@
`default_nettype none

module cau_prep
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [2:0]        i_op,
    input  wire logic signed [31:0] i_a_re,
    input  wire logic signed [31:0] i_a_im,
    input  wire logic signed [31:0] i_b_re,
    input  wire logic signed [31:0] i_b_im,
    output logic                   o_valid,
    output t_side                  o_side,
    output logic [DEN_W-1:0]       o_den,
    output t_lane                  o_lane_re,
    output t_lane                  o_lane_im
);

    localparam int NW = DEN_W + FRAC_BITS;

    function automatic logic [32:0] sat33(input logic signed [32:0] v);
        logic [32:0] res;
        if (v[32] != v[31]) begin
            res = {1'b1, v[32] ? S32_MIN : S32_MAX};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

    // ---- stage 1: products and linear ops
    logic signed [63:0] w_p_rr, w_p_ii, w_p_ri, w_p_ir, w_p_d1, w_p_d2;
    logic [32:0] w_lin_re, w_lin_im;

    assign w_p_rr = i_a_re * i_b_re;
    assign w_p_ii = i_a_im * i_b_im;
    assign w_p_ri = i_a_re * i_b_im;
    assign w_p_ir = i_a_im * i_b_re;
    assign w_p_d1 = i_b_re * i_b_re;
    assign w_p_d2 = i_b_im * i_b_im;

    always_comb begin
        case (t_op'(i_op))
            OP_ADD: begin
                w_lin_re = sat33(33'(i_a_re) + 33'(i_b_re));
                w_lin_im = sat33(33'(i_a_im) + 33'(i_b_im));
            end
            OP_SUB: begin
                w_lin_re = sat33(33'(i_a_re) - 33'(i_b_re));
                w_lin_im = sat33(33'(i_a_im) - 33'(i_b_im));
            end
            OP_NEG: begin
                w_lin_re = sat33(-33'(i_a_re));
                w_lin_im = sat33(-33'(i_a_im));
            end
            default: begin
                w_lin_re = '0;
                w_lin_im = '0;
            end
        endcase
    end

    logic               r1_valid;
    logic [2:0]         r1_op;
    logic signed [63:0] r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir, r1_p_d1, r1_p_d2;
    logic [31:0]        r1_lin_re, r1_lin_im;
    logic               r1_lin_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_op      <= i_op;
            r1_p_rr    <= w_p_rr;
            r1_p_ii    <= w_p_ii;
            r1_p_ri    <= w_p_ri;
            r1_p_ir    <= w_p_ir;
            r1_p_d1    <= w_p_d1;
            r1_p_d2    <= w_p_d2;
            r1_lin_re  <= w_lin_re[31:0];
            r1_lin_im  <= w_lin_im[31:0];
            r1_lin_ovf <= w_lin_re[32] | w_lin_im[32];
        end
    end

    // ---- stage 2: sums of products, divisor magnitude
    logic               r2_valid;
    logic [2:0]         r2_op;
    logic signed [64:0] r2_mre, r2_mim, r2_dre, r2_dim;
    logic [DEN_W-1:0]   r2_den;
    logic [31:0]        r2_lin_re, r2_lin_im;
    logic               r2_lin_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_op      <= r1_op;
            r2_mre     <= 65'(r1_p_rr) - 65'(r1_p_ii);
            r2_mim     <= 65'(r1_p_ri) + 65'(r1_p_ir);
            r2_dre     <= 65'(r1_p_rr) + 65'(r1_p_ii);
            r2_dim     <= 65'(r1_p_ir) - 65'(r1_p_ri);
            r2_den     <= DEN_W'($unsigned(r1_p_d1)) + DEN_W'($unsigned(r1_p_d2));
            r2_lin_re  <= r1_lin_re;
            r2_lin_im  <= r1_lin_im;
            r2_lin_ovf <= r1_lin_ovf;
        end
    end

    // ---- stage 3: multiply rescale, divider setup
    logic signed [64:0] w_sre, w_sim;
    logic               w_ovf_re, w_ovf_im;
    logic [31:0]        w_mul_re, w_mul_im;
    logic               w_neg_re, w_neg_im;
    logic [DEN_W-1:0]   w_mag_re, w_mag_im;
    logic [NW-1:0]      w_n_re, w_n_im;
    logic [DEN_W-1:0]   w_hi_re, w_hi_im;
    t_side              w_side;
    t_lane              w_lane_re, w_lane_im;

    always_comb begin
        // floor shift, then clamp to 32 bits
        w_sre    = r2_mre >>> FRAC_BITS;
        w_sim    = r2_mim >>> FRAC_BITS;
        w_ovf_re = (w_sre[64:31] != {34{w_sre[31]}});
        w_ovf_im = (w_sim[64:31] != {34{w_sim[31]}});
        w_mul_re = w_ovf_re ? (w_sre[64] ? S32_MIN : S32_MAX) : w_sre[31:0];
        w_mul_im = w_ovf_im ? (w_sim[64] ? S32_MIN : S32_MAX) : w_sim[31:0];

        // numerator magnitude never exceeds 2^63
        w_neg_re = r2_dre[64];
        w_neg_im = r2_dim[64];
        w_mag_re = w_neg_re ? DEN_W'(-r2_dre) : DEN_W'(r2_dre);
        w_mag_im = w_neg_im ? DEN_W'(-r2_dim) : DEN_W'(r2_dim);
        w_n_re   = NW'(w_mag_re) << FRAC_BITS;
        w_n_im   = NW'(w_mag_im) << FRAC_BITS;
        w_hi_re  = DEN_W'(w_n_re[NW-1:QUO_BITS]);
        w_hi_im  = DEN_W'(w_n_im[NW-1:QUO_BITS]);

        w_lane_re.rem = w_hi_re;
        w_lane_re.num = w_n_re[QUO_BITS-1:0];
        w_lane_re.quo = '0;
        w_lane_im.rem = w_hi_im;
        w_lane_im.num = w_n_im[QUO_BITS-1:0];
        w_lane_im.quo = '0;

        w_side         = '0;
        w_side.neg_re  = w_neg_re;
        w_side.neg_im  = w_neg_im;
        // quotient would need more than QUO_BITS bits
        w_side.big_re  = (w_hi_re >= r2_den);
        w_side.big_im  = (w_hi_im >= r2_den);
        case (t_op'(r2_op))
            OP_ADD, OP_SUB, OP_NEG: begin
                w_side.lin_re  = r2_lin_re;
                w_side.lin_im  = r2_lin_im;
                w_side.lin_ovf = r2_lin_ovf;
            end
            OP_MUL: begin
                w_side.lin_re  = w_mul_re;
                w_side.lin_im  = w_mul_im;
                w_side.lin_ovf = w_ovf_re | w_ovf_im;
            end
            OP_DIV: begin
                w_side.is_div = 1'b1;
                w_side.dz     = (r2_den == '0);
            end
            default: begin
                w_side.lin_ovf = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r2_valid;
        end
        if (i_en) begin
            o_side    <= w_side;
            o_den     <= r2_den;
            o_lane_re <= w_lane_re;
            o_lane_im <= w_lane_im;
        end
    end

endmodule

`default_nettype wire

@@ rtl/cau_div_step.sv @@
`default_nettype none

module cau_div_step
    import cau_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire t_side            i_side,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire t_lane            i_lane_re,
    input  wire t_lane            i_lane_im,
    output logic                  o_valid,
    output t_side                 o_side,
    output logic [DEN_W-1:0]      o_den,
    output t_lane                 o_lane_re,
    output t_lane                 o_lane_im
);

    // one restoring step; remainder stays below den <= 2^63
    function automatic t_lane step(input t_lane l, input logic [DEN_W-1:0] den);
        t_lane            res;
        logic [DEN_W-1:0] t;
        t       = {l.rem[DEN_W-2:0], l.num[QUO_BITS-1]};
        res.num = {l.num[QUO_BITS-2:0], 1'b0};
        if (t >= den) begin
            res.rem = t - den;
            res.quo = {l.quo[QUO_BITS-2:0], 1'b1};
        end else begin
            res.rem = t;
            res.quo = {l.quo[QUO_BITS-2:0], 1'b0};
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_side    <= i_side;
            o_den     <= i_den;
            o_lane_re <= step(i_lane_re, i_den);
            o_lane_im <= step(i_lane_im, i_den);
        end
    end

endmodule

`default_nettype wire

@@ rtl/complex_arithmetic_unit.sv @@
// Complex arithmetic unit, signed fixed point with FRAC_BITS fraction bits.
// Input stream (s_axis): one word per operation. tdata carries a_real, a_imag,
// b_real, b_imag (32 bits each, lowest first); tuser carries the operation
// code (add, subtract, negate a, multiply, divide; other codes give zero).
// Output stream (m_axis): one word per input word, in order. tdata carries
// result_real, result_imag; tuser carries overflow and divide_by_zero.
// The path has three setup stages (products, sums, rescale and
// divider setup), 34 divider steps (one quotient bit per step, one
// 64-bit compare/subtract each), and the output register. Every operation
// takes the same path, so order is kept.
// Throughput is one word per cycle unless the pipeline holds. The whole
// pipeline advances together whenever the output register is empty or being
// taken; when the receiver holds tready low with a word pending, every
// stage holds and s_axis_tready drops, so nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits; the pipeline
// contents are discarded and no word comes out until new ones go in.
`default_nettype none

module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [127:0] i_s_axis_tdata,   // a_real, a_imag, b_real, b_imag
    input  wire logic [2:0]   i_s_axis_tuser,   // operation
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [63:0]       o_m_axis_tdata,   // result_real, result_imag
    output logic [1:0]        o_m_axis_tuser    // overflow, divide_by_zero
);

    // global advance: output slot free or being emptied
    logic w_en;
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    logic             w_valid [0:QUO_BITS];
    t_side            w_side  [0:QUO_BITS];
    logic [DEN_W-1:0] w_den   [0:QUO_BITS];
    t_lane            w_re    [0:QUO_BITS];
    t_lane            w_im    [0:QUO_BITS];

    cau_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_s_axis_tvalid),
        .i_op      (i_s_axis_tuser),
        .i_a_re    (i_s_axis_tdata[31:0]),
        .i_a_im    (i_s_axis_tdata[63:32]),
        .i_b_re    (i_s_axis_tdata[95:64]),
        .i_b_im    (i_s_axis_tdata[127:96]),
        .o_valid   (w_valid[0]),
        .o_side    (w_side[0]),
        .o_den     (w_den[0]),
        .o_lane_re (w_re[0]),
        .o_lane_im (w_im[0])
    );

    // divider chain, most significant quotient bit first
    for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
        cau_div_step u_step (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_valid   (w_valid[g]),
            .i_side    (w_side[g]),
            .i_den     (w_den[g]),
            .i_lane_re (w_re[g]),
            .i_lane_im (w_im[g]),
            .o_valid   (w_valid[g+1]),
            .o_side    (w_side[g+1]),
            .o_den     (w_den[g+1]),
            .o_lane_re (w_re[g+1]),
            .o_lane_im (w_im[g+1])
        );
    end

    // quotient magnitude to saturated signed 32 bits; top bit is overflow
    function automatic logic [32:0] quo_sat(input logic big, input logic neg,
                                            input logic [QUO_BITS-1:0] q);
        logic [32:0]         res;
        logic [QUO_BITS-1:0] nq;
        nq = -q;
        if (big) begin
            res = {1'b1, neg ? S32_MIN : S32_MAX};
        end else if (neg) begin
            if (q > QUO_BITS'(S32_MIN)) begin
                res = {1'b1, S32_MIN};
            end else begin
                res = {1'b0, nq[31:0]};
            end
        end else if (q > QUO_BITS'(S32_MAX)) begin
            res = {1'b1, S32_MAX};
        end else begin
            res = {1'b0, q[31:0]};
        end
        return res;
    endfunction

    t_side       w_last;
    logic [32:0] w_qre, w_qim;
    logic [31:0] n_re, n_im;
    logic        n_ovf, n_dz;

    assign w_last = w_side[QUO_BITS];

    always_comb begin
        w_qre = quo_sat(w_last.big_re, w_last.neg_re, w_re[QUO_BITS].quo);
        w_qim = quo_sat(w_last.big_im, w_last.neg_im, w_im[QUO_BITS].quo);
        if (!w_last.is_div) begin
            n_re  = w_last.lin_re;
            n_im  = w_last.lin_im;
            n_ovf = w_last.lin_ovf;
            n_dz  = 1'b0;
        end else if (w_last.dz) begin
            n_re  = '0;
            n_im  = '0;
            n_ovf = 1'b0;
            n_dz  = 1'b1;
        end else begin
            n_re  = w_qre[31:0];
            n_im  = w_qim[31:0];
            n_ovf = w_qre[32] | w_qim[32];
            n_dz  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_axis_tvalid <= 1'b0;
        end else if (w_en) begin
            o_m_axis_tvalid <= w_valid[QUO_BITS];
        end
        if (w_en) begin
            o_m_axis_tdata <= {n_im, n_re};
            o_m_axis_tuser <= {n_dz, n_ovf};
        end
    end

endmodule

`default_nettype wire
